>>> hdl/assert_macros.svh
// Assertion macros shared by the positional list engine RTL.
// Included by the top level; expects a clock named i_clk and reset i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PLIST_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PLIST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/plist_pkg.sv
// Shared types and constants of the positional list engine.
// No dependencies; every other RTL file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package plist_pkg;

    localparam int ACTION_W    = 4;
    localparam int POS_W       = 4;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 3;
    localparam int INDEX_W     = 4;
    localparam int COUNT_W     = 5;
    localparam int MAX_RESULTS = 16;
    localparam int MCNT_W      = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND  = 4'd0,
        ACT_INSERT  = 4'd1,
        ACT_DELETE  = 4'd2,
        ACT_GET     = 4'd3,
        ACT_PRIOR   = 4'd4,
        ACT_NEXT    = 4'd5,
        ACT_REPLACE = 4'd6,
        ACT_SWAP    = 4'd7,
        ACT_LOCATE  = 4'd8
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_RANGE     = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_ZERO      = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SH_RD,
        S_SH_WR,
        S_SW_A,
        S_SW_B,
        S_SW_C,
        S_LC_RD,
        S_LC_CMP,
        S_RESP
    } t_state;

    typedef enum logic [2:0] {
        RD_PA,
        RD_PA_M1,
        RD_PA_P1,
        RD_PB,
        RD_PTR,
        RD_PTR_M1,
        RD_PTR_P1
    } t_rd_sel;

    typedef enum logic [1:0] {
        WA_COUNT,
        WA_PA,
        WA_PB,
        WA_PTR
    } t_wr_addr;

    typedef enum logic [1:0] {
        WD_VALUE,
        WD_RDATA,
        WD_TEMP
    } t_wr_data;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } t_cnt_op;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_LOAD_N,
        PTR_LOAD_PA,
        PTR_ZERO,
        PTR_INC,
        PTR_DEC
    } t_ptr_op;

    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic [POS_W-1:0]          position;
        logic [POS_W-1:0]          position_b;
        logic signed [VALUE_W-1:0] value;
        logic                      clear_all;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] data;
        logic [INDEX_W-1:0]        match_index;
        logic [COUNT_W-1:0]        count;
        logic                      last;
    } t_rsp;

    // Controller to datapath
    typedef struct packed {
        logic     accept;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     wr_en;
        t_wr_addr wr_addr;
        t_wr_data wr_data;
        t_cnt_op  cnt_op;
        t_ptr_op  ptr_op;
        logic     temp_load;
        logic     stat_load;
        logic     stat_locate_end;
        logic     pend_take;
        logic     emit;
        logic     emit_last;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                clear;
        t_status             chk;
        logic                ptr_at_pa;
        logic                ptr_last;
        logic                ptr_end;
        logic                mcnt_full;
        logic                match;
        logic                pend_valid;
        logic                out_free;
        logic                full;
    } t_sts;

endpackage

`default_nettype wire

>>> hdl/plist_if.sv
// Valid/ready channel interfaces for requests and results of the list engine.
// Depends on plist_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface plist_req_if;
    import plist_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [ACTION_W-1:0]       action;
    logic [POS_W-1:0]          position;
    logic [POS_W-1:0]          position_b;
    logic signed [VALUE_W-1:0] value;
    logic                      clear_all;

    modport source (output valid, action, position, position_b, value, clear_all,
                    input ready);
    modport sink (input valid, action, position, position_b, value, clear_all,
                  output ready);
endinterface

interface plist_rsp_if;
    import plist_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] data;
    logic [INDEX_W-1:0]        match_index;
    logic [COUNT_W-1:0]        count;
    logic                      last;

    modport source (output valid, status, data, match_index, count, last,
                    input ready);
    modport sink (input valid, status, data, match_index, count, last,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/plist_ctrl.sv
// Sequencing state machine of the list engine: issues datapath commands.
// Depends on plist_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plist_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire plist_pkg::t_sts i_sts,
    output plist_pkg::t_cmd    o_cmd
);
    import plist_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // hold the input closed while reset is asserted
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.clear) begin
                    o_cmd.cnt_op    = CNT_CLR;
                    o_cmd.stat_load = 1'b1;
                    n_state         = S_RESP;
                end else if (i_sts.chk != ST_OK) begin
                    o_cmd.stat_load = 1'b1;
                    n_state         = S_RESP;
                end else begin
                    o_cmd.stat_load = 1'b1;
                    n_state         = S_RESP;
                    case (i_sts.action)
                        ACT_APPEND: begin
                            o_cmd.wr_en   = 1'b1;
                            o_cmd.wr_addr = WA_COUNT;
                            o_cmd.wr_data = WD_VALUE;
                            o_cmd.cnt_op  = CNT_INC;
                        end
                        ACT_REPLACE: begin
                            o_cmd.wr_en   = 1'b1;
                            o_cmd.wr_addr = WA_PA;
                            o_cmd.wr_data = WD_VALUE;
                        end
                        ACT_GET: begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_PA;
                        end
                        ACT_PRIOR: begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_PA_M1;
                        end
                        ACT_NEXT: begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_PA_P1;
                        end
                        ACT_INSERT: begin
                            o_cmd.ptr_op = PTR_LOAD_N;
                            n_state      = S_SH_RD;
                        end
                        ACT_DELETE: begin
                            o_cmd.ptr_op = PTR_LOAD_PA;
                            n_state      = S_SH_RD;
                        end
                        ACT_SWAP: begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_PA;
                            n_state      = S_SW_A;
                        end
                        ACT_LOCATE: begin
                            o_cmd.stat_load = 1'b0;
                            o_cmd.ptr_op    = PTR_ZERO;
                            n_state         = S_LC_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SH_RD: begin
                if (i_sts.action == ACT_INSERT) begin
                    if (i_sts.ptr_at_pa) begin
                        o_cmd.wr_en   = 1'b1;
                        o_cmd.wr_addr = WA_PA;
                        o_cmd.wr_data = WD_VALUE;
                        o_cmd.cnt_op  = CNT_INC;
                        n_state       = S_RESP;
                    end else begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = RD_PTR_M1;
                        n_state      = S_SH_WR;
                    end
                end else begin
                    if (i_sts.ptr_last) begin
                        o_cmd.cnt_op = CNT_DEC;
                        n_state      = S_RESP;
                    end else begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = RD_PTR_P1;
                        n_state      = S_SH_WR;
                    end
                end
            end
            S_SH_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = WA_PTR;
                o_cmd.wr_data = WD_RDATA;
                o_cmd.ptr_op  = (i_sts.action == ACT_INSERT) ? PTR_DEC : PTR_INC;
                n_state       = S_SH_RD;
            end
            S_SW_A: begin
                o_cmd.temp_load = 1'b1;
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_sel    = RD_PB;
                n_state         = S_SW_B;
            end
            S_SW_B: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = WA_PA;
                o_cmd.wr_data = WD_RDATA;
                n_state       = S_SW_C;
            end
            S_SW_C: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = WA_PB;
                o_cmd.wr_data = WD_TEMP;
                n_state       = S_RESP;
            end
            S_LC_RD: begin
                if (i_sts.ptr_end || i_sts.mcnt_full) begin
                    o_cmd.stat_locate_end = 1'b1;
                    n_state               = S_RESP;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_PTR;
                    n_state      = S_LC_CMP;
                end
            end
            S_LC_CMP: begin
                if (!i_sts.match) begin
                    o_cmd.ptr_op = PTR_INC;
                    n_state      = S_LC_RD;
                end else if (!i_sts.pend_valid || i_sts.out_free) begin
                    // release the held match as a non-final result, hold the new one
                    o_cmd.emit      = i_sts.pend_valid;
                    o_cmd.pend_take = 1'b1;
                    o_cmd.ptr_op    = PTR_INC;
                    n_state         = S_LC_RD;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/plist_dp.sv
// Datapath of the list engine: list memory, count, walk pointer, checks and
// the output register. Depends on plist_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plist_dp #(
    parameter int DEPTH = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire plist_pkg::t_req i_req,
    input  wire plist_pkg::t_cmd i_cmd,
    input  wire logic            i_out_ready,
    output plist_pkg::t_sts      o_sts,
    output logic                 o_out_valid,
    output plist_pkg::t_rsp      o_out
);
    import plist_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam int XW   = CMPW + 1;

    logic [VALUE_W-1:0]  r_mem [DEPTH];

    logic [ACTION_W-1:0] r_action;
    logic [POS_W-1:0]    r_pa;
    logic [POS_W-1:0]    r_pb;
    logic [VALUE_W-1:0]  r_value;
    logic                r_clear;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_ptr;
    logic [VALUE_W-1:0]  r_rdata;
    logic [VALUE_W-1:0]  r_temp;
    t_status             r_status;
    logic                r_take;
    logic                r_pend_valid;
    logic [CW-1:0]       r_pend_idx;
    logic [MCNT_W-1:0]   r_mcnt;
    logic                r_out_valid;
    t_rsp                r_out;

    logic [XW-1:0]       w_pa_x;
    logic [XW-1:0]       w_pb_x;
    logic [XW-1:0]       w_n_x;
    logic [XW-1:0]       w_ptr_x;
    logic [XW-1:0]       w_rd_x;
    logic [XW-1:0]       w_wr_x;
    logic [AW-1:0]       w_rd_addr;
    logic [AW-1:0]       w_wr_addr;
    logic [VALUE_W-1:0]  w_wr_data;
    logic                w_zero;
    logic                w_full;
    logic                w_out_free;
    t_status             w_chk;

    assign w_pa_x  = XW'(r_pa);
    assign w_pb_x  = XW'(r_pb);
    assign w_n_x   = XW'(r_count);
    assign w_ptr_x = XW'(r_ptr);
    assign w_zero  = (r_value == '0);
    assign w_full  = (w_n_x >= XW'(DEPTH));
    assign w_out_free = !r_out_valid || i_out_ready;

    // Request checks: zero value first, then position, then full list.
    always_comb begin
        w_chk = ST_OK;
        if (!r_clear) begin
            unique case (r_action) inside
                ACT_APPEND: begin
                    if (w_zero)      w_chk = ST_ZERO;
                    else if (w_full) w_chk = ST_FULL;
                end
                ACT_INSERT: begin
                    if (w_zero)              w_chk = ST_ZERO;
                    else if (w_pa_x > w_n_x) w_chk = ST_RANGE;
                    else if (w_full)         w_chk = ST_FULL;
                end
                ACT_REPLACE: begin
                    if (w_zero)               w_chk = ST_ZERO;
                    else if (w_pa_x >= w_n_x) w_chk = ST_RANGE;
                end
                ACT_DELETE, ACT_GET: begin
                    if (w_pa_x >= w_n_x) w_chk = ST_RANGE;
                end
                ACT_PRIOR: begin
                    if (w_pa_x == '0 || w_pa_x >= w_n_x) w_chk = ST_RANGE;
                end
                ACT_NEXT: begin
                    if ((w_pa_x + 1'b1) >= w_n_x) w_chk = ST_RANGE;
                end
                ACT_SWAP: begin
                    if (w_pa_x >= w_n_x || w_pb_x >= w_n_x) w_chk = ST_RANGE;
                end
                default: begin
                    w_chk = ST_OK;
                end
            endcase
        end
    end

    always_comb begin
        case (i_cmd.rd_sel)
            RD_PA:     w_rd_x = w_pa_x;
            RD_PA_M1:  w_rd_x = w_pa_x - 1'b1;
            RD_PA_P1:  w_rd_x = w_pa_x + 1'b1;
            RD_PB:     w_rd_x = w_pb_x;
            RD_PTR:    w_rd_x = w_ptr_x;
            RD_PTR_M1: w_rd_x = w_ptr_x - 1'b1;
            RD_PTR_P1: w_rd_x = w_ptr_x + 1'b1;
            default:   w_rd_x = w_ptr_x;
        endcase
        case (i_cmd.wr_addr)
            WA_COUNT: w_wr_x = w_n_x;
            WA_PA:    w_wr_x = w_pa_x;
            WA_PB:    w_wr_x = w_pb_x;
            WA_PTR:   w_wr_x = w_ptr_x;
            default:  w_wr_x = w_ptr_x;
        endcase
        case (i_cmd.wr_data)
            WD_VALUE: w_wr_data = r_value;
            WD_RDATA: w_wr_data = r_rdata;
            WD_TEMP:  w_wr_data = r_temp;
            default:  w_wr_data = r_value;
        endcase
    end

    assign w_rd_addr = w_rd_x[AW-1:0];
    assign w_wr_addr = w_wr_x[AW-1:0];

    // List memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    // Request and payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action <= i_req.action;
            r_pa     <= i_req.position;
            r_pb     <= i_req.position_b;
            r_value  <= i_req.value;
            r_clear  <= i_req.clear_all;
        end
        if (i_cmd.temp_load) begin
            r_temp <= r_rdata;
        end
        if (i_cmd.emit) begin
            r_out.status      <= i_cmd.emit_last ? r_status : ST_OK;
            r_out.data        <= (i_cmd.emit_last && r_take) ? r_rdata : '0;
            r_out.match_index <= INDEX_W'(r_pend_idx);
            r_out.count       <= COUNT_W'(r_count);
            r_out.last        <= i_cmd.emit_last;
        end
        case (i_cmd.ptr_op)
            PTR_LOAD_N:  r_ptr <= r_count;
            PTR_LOAD_PA: r_ptr <= w_pa_x[CW-1:0];
            PTR_ZERO:    r_ptr <= '0;
            PTR_INC:     r_ptr <= CW'(r_ptr + 1'b1);
            PTR_DEC:     r_ptr <= CW'(r_ptr - 1'b1);
            default:     r_ptr <= r_ptr;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_status     <= ST_OK;
            r_take       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_pend_idx   <= '0;
            r_mcnt       <= '0;
        end else begin
            case (i_cmd.cnt_op)
                CNT_INC: r_count <= CW'(r_count + 1'b1);
                CNT_DEC: r_count <= CW'(r_count - 1'b1);
                CNT_CLR: r_count <= '0;
                default: r_count <= r_count;
            endcase
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.accept) begin
                r_status     <= ST_OK;
                r_take       <= 1'b0;
                r_pend_valid <= 1'b0;
                r_pend_idx   <= '0;
                r_mcnt       <= '0;
            end else begin
                if (i_cmd.stat_load) begin
                    r_status <= w_chk;
                    r_take   <= (w_chk == ST_OK) && !r_clear &&
                                (r_action == ACT_GET || r_action == ACT_PRIOR ||
                                 r_action == ACT_NEXT);
                end
                if (i_cmd.stat_locate_end) begin
                    r_status <= r_pend_valid ? ST_OK : ST_NOT_FOUND;
                end
                if (i_cmd.pend_take) begin
                    r_pend_valid <= 1'b1;
                    r_pend_idx   <= r_ptr;
                    r_mcnt       <= MCNT_W'(r_mcnt + 1'b1);
                end
            end
        end
    end

    assign o_sts.action     = r_action;
    assign o_sts.clear      = r_clear;
    assign o_sts.chk        = w_chk;
    assign o_sts.ptr_at_pa  = (w_ptr_x == w_pa_x);
    assign o_sts.ptr_last   = ((w_ptr_x + 1'b1) >= w_n_x);
    assign o_sts.ptr_end    = (w_ptr_x >= w_n_x);
    assign o_sts.mcnt_full  = (r_mcnt == MCNT_W'(MAX_RESULTS));
    assign o_sts.match      = (r_rdata == r_value) && !w_zero;
    assign o_sts.pend_valid = r_pend_valid;
    assign o_sts.out_free   = w_out_free;
    assign o_sts.full       = w_full;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

>>> hdl/positional_list_engine_unit.sv
// Top level of the positional list engine: controller, datapath, assertions.
// Depends on plist_pkg, plist_if, plist_ctrl, plist_dp and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// Positional list engine. Keeps an ordered list of up to DEPTH nonzero signed
// 32-bit words and serves one request transaction at a time on i_req:
// append, insert, delete, get, prior, next, replace, swap, locate or clear.
// Each request yields one result transaction on o_rsp with last set, except
// locate, which yields one result per match (ascending index, at most 16,
// last on the final one) or a single not-found result. Failed requests leave
// the list untouched and report an error status. The list lives in a
// single-port-write, registered-read memory, so every element move costs one
// read and one write: insert and delete move the shifted entries one at a
// time, swap moves two entries, and locate reads the entries in turn. A
// stalled result side holds a request while the output register is full.
// i_req.ready is high only while no request is in progress and reset is
// released; the result register lets the last result wait for o_rsp.ready
// while the next request is accepted. The list memory is not cleared at
// reset: only entries below the element count are ever read.
module positional_list_engine_unit #(
    parameter int DEPTH = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    plist_req_if.sink   i_req,
    plist_rsp_if.source o_rsp
);
    import plist_pkg::*;

    t_req w_req;
    t_rsp w_rsp;
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;
    logic w_in_acc;
    logic w_out_valid;

    // Gather the request fields into one word for the datapath
    assign w_req.action     = i_req.action;
    assign w_req.position   = i_req.position;
    assign w_req.position_b = i_req.position_b;
    assign w_req.value      = i_req.value;
    assign w_req.clear_all  = i_req.clear_all;
    assign i_req.ready      = w_in_ready;
    assign w_in_acc         = i_req.valid && w_in_ready;

    plist_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    plist_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .i_cmd       (w_cmd),
        .i_out_ready (o_rsp.ready),
        .o_sts       (w_sts),
        .o_out_valid (w_out_valid),
        .o_out       (w_rsp)
    );

    // Drive the result channel straight from the output register
    assign o_rsp.valid       = w_out_valid;
    assign o_rsp.status      = w_rsp.status;
    assign o_rsp.data        = w_rsp.data;
    assign o_rsp.match_index = w_rsp.match_index;
    assign o_rsp.count       = w_rsp.count;
    assign o_rsp.last        = w_rsp.last;

`include "assert_macros.svh"

    // An accepted request keeps the input side closed on the next cycle.
    `PLIST_ASSERT_NEXT(a_busy_after_accept, w_in_acc, !w_in_ready, "input ready after accept")
    // Never overwrite a result that the sink has not yet taken.
    `PLIST_ASSERT_IMPL(a_emit_into_free, w_cmd.emit, w_sts.out_free, "result overwritten")
    // Never grow the list past its capacity.
    `PLIST_ASSERT_IMPL(a_no_grow_full, w_cmd.cnt_op == CNT_INC, !w_sts.full, "count past depth")

endmodule

`default_nettype wire

>>> bench/plist_list_checker.sv
`timescale 1ns / 1ps
// Result checker for the positional list engine: mirrors the list contents and
// compares every result transaction. Depends on plist_pkg and plist_if.

module plist_list_checker #(
    parameter int DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    plist_req_if i_req,
    plist_rsp_if i_rsp,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked
);
    import plist_pkg::*;

    logic signed [VALUE_W-1:0] mirror_list [DEPTH];
    int                        mirror_len;
    t_rsp                      pending_results [$];
    int                        mismatches;
    int                        checked;

    task automatic queue_result(input t_status st, input logic signed [VALUE_W-1:0] rd,
                                input logic [INDEX_W-1:0] idx, input logic lst);
        t_rsp r;
        r.status      = st;
        r.data        = rd;
        r.match_index = idx;
        r.count       = COUNT_W'(mirror_len);
        r.last        = lst;
        pending_results.push_back(r);
    endtask

    // Apply one request to the mirror and queue the results it must produce.
    task automatic apply_request(input t_req r);
        t_status                   st;
        logic signed [VALUE_W-1:0] rd;
        logic signed [VALUE_W-1:0] tmp;
        int                        n;
        int                        pa;
        int                        pb;
        int                        hits;
        st   = ST_OK;
        rd   = '0;
        n    = mirror_len;
        pa   = int'(r.position);
        pb   = int'(r.position_b);
        hits = 0;
        if (r.clear_all) begin
            mirror_len = 0;
            queue_result(ST_OK, '0, '0, 1'b1);
            return;
        end
        case (r.action)
            ACT_APPEND: begin
                if (r.value == 0) st = ST_ZERO;
                else if (n >= DEPTH) st = ST_FULL;
                else begin
                    mirror_list[n] = r.value;
                    mirror_len     = n + 1;
                end
            end
            ACT_INSERT: begin
                if (r.value == 0) st = ST_ZERO;
                else if (pa > n) st = ST_RANGE;
                else if (n >= DEPTH) st = ST_FULL;
                else begin
                    for (int i = n; i > pa; i--) mirror_list[i] = mirror_list[i-1];
                    mirror_list[pa] = r.value;
                    mirror_len      = n + 1;
                end
            end
            ACT_DELETE: begin
                if (pa >= n) st = ST_RANGE;
                else begin
                    for (int i = pa; i + 1 < n; i++) mirror_list[i] = mirror_list[i+1];
                    mirror_len = n - 1;
                end
            end
            ACT_GET: begin
                if (pa >= n) st = ST_RANGE;
                else rd = mirror_list[pa];
            end
            ACT_PRIOR: begin
                if (pa < 1 || pa >= n) st = ST_RANGE;
                else rd = mirror_list[pa-1];
            end
            ACT_NEXT: begin
                if (pa + 1 >= n) st = ST_RANGE;
                else rd = mirror_list[pa+1];
            end
            ACT_REPLACE: begin
                if (r.value == 0) st = ST_ZERO;
                else if (pa >= n) st = ST_RANGE;
                else mirror_list[pa] = r.value;
            end
            ACT_SWAP: begin
                if (pa >= n || pb >= n) st = ST_RANGE;
                else begin
                    tmp             = mirror_list[pa];
                    mirror_list[pa] = mirror_list[pb];
                    mirror_list[pb] = tmp;
                end
            end
            ACT_LOCATE: begin
                for (int i = 0; i < n && hits < MAX_RESULTS; i++) begin
                    if (r.value != 0 && mirror_list[i] == r.value) begin
                        queue_result(ST_OK, '0, INDEX_W'(i), 1'b0);
                        hits++;
                    end
                end
                if (hits == 0) queue_result(ST_NOT_FOUND, '0, '0, 1'b1);
                else pending_results[$].last = 1'b1;
                return;
            end
            default: ;
        endcase
        queue_result(st, rd, '0, 1'b1);
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        t_req req;
        if (!i_rst_n) begin
            pending_results.delete();
            mirror_len = 0;
            mismatches = 0;
            checked    = 0;
        end else begin
            // A result can never belong to a request accepted on the same edge.
            if (i_rsp.valid && i_rsp.ready) begin
                checked++;
                if (pending_results.size() == 0) begin
                    $error("result with nothing pending: status %0d data %0d count %0d",
                           i_rsp.status, i_rsp.data, i_rsp.count);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, i_rsp.status);
                    check_field("data", want.data, i_rsp.data);
                    check_field("match_index", want.match_index, i_rsp.match_index);
                    check_field("count", want.count, i_rsp.count);
                    check_field("last", want.last, i_rsp.last);
                end
            end
            if (i_req.valid && i_req.ready) begin
                req.action     = i_req.action;
                req.position   = i_req.position;
                req.position_b = i_req.position_b;
                req.value      = i_req.value;
                req.clear_all  = i_req.clear_all;
                apply_request(req);
            end
        end
        o_errors  <= mismatches;
        o_pending <= pending_results.size();
        o_checked <= checked;
    end

endmodule

>>> bench/positional_list_engine_unit_tb.sv
`timescale 1ns / 1ps
// Top of the positional list engine bench: clock, reset, request stimulus,
// result back-pressure and verdict. Depends on plist_pkg, plist_if, the checker.

module positional_list_engine_unit_tb;
    import plist_pkg::*;

    localparam int DEPTH          = 16;
    localparam int RAND_ITEMS     = 95;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 60;

    logic clk;
    logic rst_n;

    plist_req_if req_ch ();
    plist_rsp_if rsp_ch ();

    int errors;
    int pending;
    int checked;

    // Stimulus bookkeeping: a running guess of the list length, used only to
    // steer positions into range, never to judge results.
    int   est_count;
    int   sent;
    int   directed_sent;
    int   rand_sent;
    int   fills;
    bit   calm;
    int   stall_left;
    int   idle_cycles;

    positional_list_engine_unit #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    plist_list_checker #(
        .DEPTH(DEPTH)
    ) i_checker (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_req    (req_ch),
        .i_rsp    (rsp_ch),
        .o_errors (errors),
        .o_pending(pending),
        .o_checked(checked)
    );

    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Values drawn from a small pool so that locate finds repeats, plus the
    // signed extremes, an occasional zero and fully random words.
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0, 1, 2, 3: return VALUE_W'($urandom_range(1, 3));
            4:          return '1;
            5:          return 32'h7fff_ffff;
            6:          return 32'h8000_0000;
            7:          return '0;
            default:    return VALUE_W'($urandom);
        endcase
    endfunction

    // Result side back-pressure: drop ready for a random stall now and then,
    // hold it high throughout a calm stretch.
    always @(posedge clk) begin
        if (stall_left > 0 && !calm) begin
            stall_left   <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
            else stall_left <= 0;
        end
    end

    // Watchdog: end the run if no transaction moves on either side for too long.
    always @(posedge clk) begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one request transaction and hold it until the engine takes it.
    // Valid stays high on return, so back-to-back requests never lower it
    // and raise it again within one time step.
    task automatic send_req(input logic [ACTION_W-1:0] act, input logic [POS_W-1:0] pa,
                            input logic [POS_W-1:0] pb, input logic [VALUE_W-1:0] val,
                            input logic clr);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.action     <= act;
        req_ch.position   <= pa;
        req_ch.position_b <= pb;
        req_ch.value      <= val;
        req_ch.clear_all  <= clr;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        sent++;
        // Advance the length guess the way a successful request would.
        if (clr) begin
            est_count = 0;
        end else begin
            case (act)
                ACT_APPEND: if (val != 0 && est_count < DEPTH) est_count++;
                ACT_INSERT: if (val != 0 && pa <= est_count && est_count < DEPTH) est_count++;
                ACT_DELETE: if (pa < est_count) est_count--;
                default: ;
            endcase
        end
        // Unused action codes are ignored by the engine: do not count them.
        if (clr || act <= ACT_LOCATE) rand_sent++;
    endtask

    // Fill the list with one key to capacity, push against the full list,
    // locate the key for a full burst of results, then shift the whole list.
    task automatic fill_burst();
        logic [VALUE_W-1:0] key;
        key = pick_value();
        if (key == 0) key = 9;
        send_req(ACT_APPEND, '0, '0, key, 1'b1);
        while (est_count < DEPTH) send_req(ACT_APPEND, 4'($urandom), 4'($urandom), key, 1'b0);
        send_req(ACT_APPEND, '0, '0, key, 1'b0);
        send_req(ACT_INSERT, 4'($urandom_range(0, 15)), '0, key, 1'b0);
        send_req(ACT_LOCATE, 4'($urandom), '0, key, 1'b0);
        send_req(ACT_DELETE, '0, '0, '0, 1'b0);
        send_req(ACT_INSERT, '0, '0, pick_value() | 32'h1, 1'b0);
        send_req(ACT_LOCATE, '0, '0, key, 1'b0);
        fills++;
    endtask

    // A request shaped by the current length: positions mostly in range.
    task automatic shaped_req();
        logic [ACTION_W-1:0] act;
        logic [POS_W-1:0]    pa;
        logic [POS_W-1:0]    pb;
        int                  hi;
        act = ACTION_W'($urandom_range(0, 8));
        hi  = (est_count == 0) ? 0 : est_count - 1;
        if (act == ACT_INSERT) pa = POS_W'($urandom_range(0, (est_count > 15) ? 15 : est_count));
        else pa = POS_W'($urandom_range(0, hi));
        pb = POS_W'($urandom_range(0, hi));
        if ($urandom_range(0, 7) == 0) pa = POS_W'($urandom);
        send_req(act, pa, pb, pick_value(), $urandom_range(0, 40) == 0);
    endtask

    initial begin
        int sel;
        req_ch.valid      = 1'b0;
        req_ch.action     = '0;
        req_ch.position   = '0;
        req_ch.position_b = '0;
        req_ch.value      = '0;
        req_ch.clear_all  = 1'b0;
        rsp_ch.ready      = 1'b0;
        rst_n             = 1'b0;
        stall_left        = 0;
        idle_cycles       = 0;
        est_count         = 0;
        sent              = 0;
        rand_sent         = 0;
        fills             = 0;
        calm              = 1'b0;

        // Hold reset at the start, then release it once for the whole run.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: empty-list errors, the check order, signed extremes,
        // every action, a swap error, ignored codes and clear overriding.
        send_req(ACT_LOCATE, 4'hf, 4'hf, 32'hffff_ffff, 1'b1);
        send_req(ACT_GET, '0, '0, '0, 1'b0);
        send_req(ACT_DELETE, '0, '0, '0, 1'b0);
        send_req(ACT_LOCATE, '0, '0, 32'd5, 1'b0);
        send_req(ACT_APPEND, '0, '0, '0, 1'b0);
        send_req(ACT_APPEND, '0, '0, 32'h8000_0000, 1'b0);
        send_req(ACT_INSERT, '0, '0, 32'h7fff_ffff, 1'b0);
        send_req(ACT_INSERT, 4'd2, '0, 32'hffff_ffff, 1'b0);
        send_req(ACT_INSERT, 4'd5, '0, 32'd3, 1'b0);
        send_req(ACT_INSERT, 4'hf, '0, '0, 1'b0);
        send_req(ACT_REPLACE, 4'hf, '0, '0, 1'b0);
        send_req(ACT_REPLACE, 4'd1, '0, 32'd5, 1'b0);
        send_req(ACT_GET, 4'd2, '0, '0, 1'b0);
        send_req(ACT_PRIOR, '0, '0, '0, 1'b0);
        send_req(ACT_PRIOR, 4'd2, '0, '0, 1'b0);
        send_req(ACT_NEXT, 4'd2, '0, '0, 1'b0);
        send_req(ACT_NEXT, '0, '0, '0, 1'b0);
        send_req(ACT_SWAP, '0, 4'd2, '0, 1'b0);
        send_req(ACT_SWAP, '0, 4'hf, '0, 1'b0);
        send_req(ACT_APPEND, '0, '0, 32'd5, 1'b0);
        send_req(ACT_LOCATE, '0, '0, 32'd5, 1'b0);
        send_req(ACT_LOCATE, '0, '0, '0, 1'b0);
        send_req(4'd9, 4'd3, 4'd3, 32'd5, 1'b0);
        send_req(4'hf, 4'hf, 4'hf, 32'hffff_ffff, 1'b0);
        send_req(ACT_DELETE, '0, '0, '0, 1'b0);
        send_req(ACT_DELETE, 4'(est_count - 1), '0, '0, 1'b0);
        directed_sent = sent;
        rand_sent     = 0;

        // Random part: mostly shaped requests, some fill bursts, some noise.
        // A calm stretch in the middle runs both sides without idling.
        while (rand_sent < RAND_ITEMS) begin
            calm = (rand_sent >= 50 && rand_sent < 75);
            sel  = $urandom_range(0, 99);
            if (sel < 6) fill_burst();
            else if (sel < 82) shaped_req();
            else send_req(ACTION_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                          VALUE_W'($urandom), $urandom_range(0, 7) == 0);
        end
        if (fills == 0) fill_burst();
        calm = 1'b0;
        req_ch.valid <= 1'b0;

        // Drain: let the checker see the last request, wait for every expected
        // result, then a margin for stragglers.
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending != 0) $error("%0d expected results never arrived", pending);

        $display("Sent %0d requests (%0d directed), checked %0d results, %0d full-list bursts",
                 sent, directed_sent, checked, fills);
        $display("Mismatches: %0d, results still pending: %0d", errors, pending);
        if (errors == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
